[rtl/hsv_pkg.sv]
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, hue constants and pipeline types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

   // pixel and result formats
   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_BITS      = 15;

   localparam int FULL_SCALE    = (1 << CHANNEL_BITS) - 1;
   localparam int HUE_STEP      = 60 << HUE_FRAC_BITS;    // one sector, scaled
   localparam int HUE_DEG_120   = 120 << HUE_FRAC_BITS;
   localparam int HUE_DEG_240   = 240 << HUE_FRAC_BITS;
   localparam int HUE_DEG_360   = 360 << HUE_FRAC_BITS;

   // pipelined divider: quotient bits retired per stage and stage count
   localparam int HUE_QUO_NEED  = $clog2(HUE_STEP + 1);
   localparam int QUO_NEED      = (HUE_QUO_NEED > CHANNEL_BITS) ? HUE_QUO_NEED
                                                                : CHANNEL_BITS;
   localparam int DIV_STEP_BITS = 2;
   localparam int DIV_STAGES    = (QUO_NEED + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
   localparam int DIV_QUO_BITS  = DIV_STAGES * DIV_STEP_BITS;
   localparam int DIV_DEN_BITS  = CHANNEL_BITS;
   localparam int DIV_NUM_BITS  = DIV_DEN_BITS + DIV_QUO_BITS;

   // width for the final hue add/subtract before truncation
   localparam int HUE_SUM_BITS  = HUE_BITS + DIV_QUO_BITS + 1;

   // per-item information that rides beside the divider stages
   typedef struct packed {
      logic [CHANNEL_BITS-1:0] hi;
      logic [HUE_BITS-1:0]     base;
      logic                    neg;
      logic                    grey;
   } hsv_side_type;

endpackage

[rtl/hsv_req_if.sv]
// ----------------------------------------------------------------------------
// hsv_req_if
// Pixel channel: valid/ready handshake with three channel levels.
// ----------------------------------------------------------------------------
interface hsv_req_if import hsv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_level;
   logic [CHANNEL_BITS-1:0] green_level;
   logic [CHANNEL_BITS-1:0] blue_level;

   modport source (output valid, output red_level, output green_level,
                   output blue_level, input ready);
   modport sink   (input valid, input red_level, input green_level,
                   input blue_level, output ready);
endinterface

[rtl/hsv_rsp_if.sv]
// ----------------------------------------------------------------------------
// hsv_rsp_if
// Result channel: valid/ready handshake with hue, saturation and value.
// ----------------------------------------------------------------------------
interface hsv_rsp_if import hsv_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [HUE_BITS-1:0]     hue_angle;
   logic [CHANNEL_BITS-1:0] saturation_level;
   logic [CHANNEL_BITS-1:0] value_level;

   modport source (output valid, output hue_angle, output saturation_level,
                   output value_level, input ready);
   modport sink   (input valid, input hue_angle, input saturation_level,
                   input value_level, output ready);
endinterface

[rtl/rgb_to_hsv_converter_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// One-pixel-per-clock RGB to HSV converter.
//
// req carries one pixel (red, green, blue levels); rsp returns hue in degrees
// times 64 (truncated, 0 for grey), saturation floor(255*(max-min)/max) and
// value max. Both channels use valid/ready; an item moves when both are high.
// Throughput is one item per cycle while rsp does not stall: stage 1 finds
// max/min and the hue sector, stage 2 forms the numerators, the two dividers
// retire two quotient bits per stage, and the last stage applies the sector
// offset into the output register. The whole pipeline advances together
// whenever the output register is empty or being taken; while rsp stalls with
// a result held, req.ready is low and every stage holds its item. Synchronous
// reset clears all valid bits; the block accepts a pixel in the first cycle
// after reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top import hsv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   hsv_req_if.sink   req,
   hsv_rsp_if.source rsp
);

   logic advance;

   // stage 1: extremes and sector
   logic [CHANNEL_BITS-1:0] hi, lo, pos, neg_term, span;
   logic [HUE_BITS-1:0]     base;

   logic                    s1_valid_ff;
   logic [CHANNEL_BITS-1:0] s1_hi_ff, s1_span_ff, s1_mag_ff;
   logic [HUE_BITS-1:0]     s1_base_ff;
   logic                    s1_neg_ff;

   // stage 2: numerators
   logic                    s2_valid_ff;
   logic [DIV_NUM_BITS-1:0] s2_hue_num_ff, s2_sat_num_ff;
   logic [CHANNEL_BITS-1:0] s2_span_ff;
   hsv_side_type            s2_side_ff;

   // divider stages
   logic                    div_valid_ff [DIV_STAGES];
   hsv_side_type            div_side_ff  [DIV_STAGES];
   logic [DIV_QUO_BITS-1:0] hue_quo, sat_quo;
   logic                    hue_rem_nz, sat_rem_nz;

   // output register
   logic                    out_valid_ff;
   logic [HUE_BITS-1:0]     out_hue_ff;
   logic [CHANNEL_BITS-1:0] out_sat_ff, out_val_ff;
   logic [HUE_SUM_BITS-1:0] hue_sum;
   hsv_side_type            last_side;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      hi = req.red_level;
      lo = req.red_level;
      if (req.green_level > hi) hi = req.green_level;
      if (req.blue_level  > hi) hi = req.blue_level;
      if (req.green_level < lo) lo = req.green_level;
      if (req.blue_level  < lo) lo = req.blue_level;
      span = hi - lo;

      // ties: red wins over green, green over blue
      if (hi == req.red_level) begin
         pos      = req.green_level;
         neg_term = req.blue_level;
         base     = (req.green_level >= req.blue_level) ? '0 : HUE_BITS'(HUE_DEG_360);
      end else if (hi == req.green_level) begin
         pos      = req.blue_level;
         neg_term = req.red_level;
         base     = HUE_BITS'(HUE_DEG_120);
      end else begin
         pos      = req.red_level;
         neg_term = req.green_level;
         base     = HUE_BITS'(HUE_DEG_240);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_hi_ff   <= hi;
         s1_span_ff <= span;
         s1_mag_ff  <= (pos >= neg_term) ? pos - neg_term : neg_term - pos;
         s1_neg_ff  <= (pos < neg_term);
         s1_base_ff <= base;

         s2_hue_num_ff   <= DIV_NUM_BITS'(s1_mag_ff) * DIV_NUM_BITS'(HUE_STEP);
         s2_sat_num_ff   <= DIV_NUM_BITS'(s1_span_ff) * DIV_NUM_BITS'(FULL_SCALE);
         s2_span_ff      <= s1_span_ff;
         s2_side_ff.hi   <= s1_hi_ff;
         s2_side_ff.base <= s1_base_ff;
         s2_side_ff.neg  <= s1_neg_ff;
         s2_side_ff.grey <= (s1_span_ff == '0);
      end
   end

   hsv_div u_hue_div (
      .clock       (clock),
      .enable      (advance),
      .dividend    (s2_hue_num_ff),
      .divisor     (s2_span_ff),
      .quotient    (hue_quo),
      .rem_nonzero (hue_rem_nz)
   );

   hsv_div u_sat_div (
      .clock       (clock),
      .enable      (advance),
      .dividend    (s2_sat_num_ff),
      .divisor     (s2_side_ff.hi),
      .quotient    (sat_quo),
      .rem_nonzero (sat_rem_nz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            div_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         div_valid_ff[0] <= s2_valid_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            div_valid_ff[i] <= div_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_side_ff[0] <= s2_side_ff;
         for (int i = 1; i < DIV_STAGES; i++) begin
            div_side_ff[i] <= div_side_ff[i-1];
         end
      end
   end

   assign last_side = div_side_ff[DIV_STAGES-1];

   // below-zero offsets round toward the lower hue: drop one more on a remainder
   always_comb begin
      if (last_side.neg) begin
         hue_sum = HUE_SUM_BITS'(last_side.base) - HUE_SUM_BITS'(hue_quo)
                   - HUE_SUM_BITS'(hue_rem_nz);
      end else begin
         hue_sum = HUE_SUM_BITS'(last_side.base) + HUE_SUM_BITS'(hue_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= div_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hue_ff <= last_side.grey ? '0 : hue_sum[HUE_BITS-1:0];
         out_sat_ff <= (last_side.hi == '0) ? '0 : sat_quo[CHANNEL_BITS-1:0];
         out_val_ff <= last_side.hi;
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.hue_angle        = out_hue_ff;
   assign rsp.saturation_level = out_sat_ff;
   assign rsp.value_level      = out_val_ff;

`ifndef NO_ASSERTIONS
   // zero saturation only happens for grey pixels, which carry hue zero
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.saturation_level == '0) |-> (rsp.hue_angle == '0))
      else $error("nonzero hue on a zero-saturation item");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.value_level == '0) |->
         (rsp.saturation_level == '0) && (rsp.hue_angle == '0))
      else $error("black item with nonzero hue or saturation");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff == $past(div_valid_ff[DIV_STAGES-1])))
      else $error("output valid does not follow the last divider stage");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(div_valid_ff[0]) && $stable(s1_valid_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

[rtl/hsv_div.sv]
// ----------------------------------------------------------------------------
// hsv_div
// Pipelined restoring divider, DIV_STEP_BITS quotient bits per stage.
// The quotient must fit in DIV_QUO_BITS (dividend < divisor << DIV_QUO_BITS).
// ----------------------------------------------------------------------------
module hsv_div import hsv_pkg::*; (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [DIV_NUM_BITS-1:0] dividend,
   input  logic [DIV_DEN_BITS-1:0] divisor,
   output logic [DIV_QUO_BITS-1:0] quotient,
   output logic                    rem_nonzero
);

   logic [DIV_DEN_BITS-1:0] rem_ff [DIV_STAGES];
   logic [DIV_QUO_BITS-1:0] low_ff [DIV_STAGES];
   logic [DIV_QUO_BITS-1:0] quo_ff [DIV_STAGES];
   logic [DIV_DEN_BITS-1:0] den_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [DIV_DEN_BITS-1:0] rem_src;
      logic [DIV_QUO_BITS-1:0] low_src;
      logic [DIV_QUO_BITS-1:0] quo_src;
      logic [DIV_DEN_BITS-1:0] den_src;
      logic [DIV_DEN_BITS-1:0] rem_in;
      logic [DIV_QUO_BITS-1:0] low_in;
      logic [DIV_QUO_BITS-1:0] quo_in;

      if (k == 0) begin : g_first
         // top bits are below the divisor, so they seed the remainder
         assign rem_src = dividend[DIV_NUM_BITS-1 -: DIV_DEN_BITS];
         assign low_src = dividend[DIV_QUO_BITS-1:0];
         assign quo_src = '0;
         assign den_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      always_comb begin
         logic [DIV_DEN_BITS:0] trial;
         rem_in = rem_src;
         low_in = low_src;
         quo_in = quo_src;
         for (int s = 0; s < DIV_STEP_BITS; s++) begin
            trial  = {rem_in, low_in[DIV_QUO_BITS-1]};
            low_in = {low_in[DIV_QUO_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_src}) begin
               rem_in = DIV_DEN_BITS'(trial - {1'b0, den_src});
               quo_in = {quo_in[DIV_QUO_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[DIV_DEN_BITS-1:0];
               quo_in = {quo_in[DIV_QUO_BITS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in;
            low_ff[k] <= low_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= den_src;
         end
      end
   end

   assign quotient    = quo_ff[DIV_STAGES-1];
   assign rem_nonzero = (rem_ff[DIV_STAGES-1] != '0);

endmodule
